>>> rtl/ris_pkg.sv
package ris_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHUNK_W    = 8;
  localparam int ROT_W      = 5;
  localparam int PAIR_W     = 2;
  localparam int PAIR_IDX_W = 4;   // index of a 2-bit pair within the value
  localparam int COUNT_W    = 2;   // results already sent for this constant
  localparam int SKIP_W     = 2;
  localparam int NIBBLE_W   = 4;

  localparam logic [VALUE_W-1:0] TOP_NIBBLE_MASK = 32'hF000_0000;
  localparam logic [VALUE_W-1:0] WRAP_SCAN_MASK  = 32'h0FFF_FFF0;
  localparam logic [ROT_W-1:0]   WRAP_ROT        = 5'd4;
  localparam logic [COUNT_W-1:0] LAST_COUNT      = 2'd3;
  // last skip_cnt value; the skip steps from zero up to it move past the rest of a chunk
  localparam logic [SKIP_W-1:0]  SKIP_LAST       = 2'd2;

endpackage

>>> rtl/rotated_immediate_splitter_unit.sv
// rotated immediate splitter
//
// input channel: value (32 bits) with in_valid / in_ready. a transfer loads the
// constant into a shift register pair (data and scan copy), 2 bits per shift.
// output channel: chunk, rotate_right, final_piece with out_valid / out_ready.
// each result is one 8-bit piece and its even rotate-right amount; OR-ing all
// pieces rotated right rebuilds the constant. final_piece marks the last one.
//
// the block works on one constant at a time. a zero constant or one with a
// non-zero top nibble goes to S_FIRST on the input transfer, and S_FIRST
// sends its first piece. the scanner then steps one bit pair per cycle, but
// holds at a piece while the output stalls; after each piece it moves past
// the rest of the byte in S_SKIP. with the receiver always ready, the time
// from one input transfer to the next is set by the scanner's walk over the
// pairs up to the last piece, the fixed first piece if any, and idle.
// in_ready rises again in the cycle after the final piece is loaded into the
// output register, so the next constant can enter while that piece waits.
//
// reset: clears the controller and drops out_valid; nothing else needs it.
// stall: while out_valid is high and out_ready low, the scanner halts at the
// next piece and holds; results are never lost or repeated.
module rotated_immediate_splitter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ris_pkg::VALUE_W-1:0]   value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ris_pkg::CHUNK_W-1:0]   chunk,
  output logic [ris_pkg::ROT_W-1:0]     rotate_right,
  output logic                          final_piece
);
  import ris_pkg::*;

  // controller states
  localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for a constant
  localparam logic [1:0] S_FIRST = 2'd1;  // zero or wrapped first piece
  localparam logic [1:0] S_SCAN  = 2'd2;  // look at one bit pair per cycle unless held at a piece
  localparam logic [1:0] S_SKIP  = 2'd3;  // move past the rest of a chunk

  logic [1:0]            state;
  logic [VALUE_W-1:0]    sr;        // value shifted right by the scan position
  logic [VALUE_W-1:0]    scan;      // same, with the wrapped nibbles masked off
  logic                  wrap;      // top nibble was non-zero
  logic [PAIR_IDX_W-1:0] pair_idx;  // scan position in pairs
  logic [COUNT_W-1:0]    count;
  logic [SKIP_W-1:0]     skip_cnt;

  logic                  slot_free;
  logic                  load_piece;
  logic                  in_wrap;
  logic                  scan_hit;
  logic                  scan_final;
  logic [PAIR_IDX_W-1:0] neg_idx;
  logic [ROT_W-1:0]      scan_rot;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign in_wrap   = |(value & TOP_NIBBLE_MASK);
  assign scan_hit  = |scan[PAIR_W-1:0];

  // a piece goes into the output register this cycle
  assign load_piece = slot_free && ((state == S_FIRST) || (state == S_SCAN && scan_hit));

  // last piece when nothing is left above this byte, or the fourth piece
  assign scan_final = !(|scan[VALUE_W-1:CHUNK_W]) || (count == LAST_COUNT);

  // rotation (32 - 2 * pair_idx) mod 32
  assign neg_idx  = '0 - pair_idx;
  assign scan_rot = {neg_idx, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_piece) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sr       <= value;
            wrap     <= in_wrap;
            scan     <= in_wrap ? (value & WRAP_SCAN_MASK) : value;
            pair_idx <= '0;
            count    <= '0;
            // zero or a wrapped top nibble starts with a fixed first piece
            state    <= (in_wrap || (value == '0)) ? S_FIRST : S_SCAN;
          end
        end
        S_FIRST: begin
          if (slot_free) begin
            // zero constant gives zero here on its own
            chunk        <= {sr[NIBBLE_W-1:0], sr[VALUE_W-1:VALUE_W-NIBBLE_W]};
            rotate_right <= wrap ? WRAP_ROT : '0;
            final_piece  <= (scan == '0);
            count        <= count + 1'b1;
            state        <= (scan == '0) ? S_IDLE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (!scan_hit) begin
            sr       <= {{PAIR_W{1'b0}}, sr[VALUE_W-1:PAIR_W]};
            scan     <= {{PAIR_W{1'b0}}, scan[VALUE_W-1:PAIR_W]};
            pair_idx <= pair_idx + 1'b1;
          end else if (slot_free) begin
            chunk        <= sr[CHUNK_W-1:0];
            rotate_right <= scan_rot;
            final_piece  <= scan_final;
            count        <= count + 1'b1;
            sr           <= {{PAIR_W{1'b0}}, sr[VALUE_W-1:PAIR_W]};
            scan         <= {{PAIR_W{1'b0}}, scan[VALUE_W-1:PAIR_W]};
            pair_idx     <= pair_idx + 1'b1;
            skip_cnt     <= '0;
            state        <= scan_final ? S_IDLE : S_SKIP;
          end
        end
        S_SKIP: begin
          sr       <= {{PAIR_W{1'b0}}, sr[VALUE_W-1:PAIR_W]};
          scan     <= {{PAIR_W{1'b0}}, scan[VALUE_W-1:PAIR_W]};
          pair_idx <= pair_idx + 1'b1;
          skip_cnt <= skip_cnt + 1'b1;
          if (skip_cnt == SKIP_LAST) begin
            state <= S_SCAN;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a non-final piece always leaves something to find
  a_skip_has_data: assert property (@(posedge clk) disable iff (rst)
    (state == S_SKIP) |-> (scan != '0))
    else $error("skip entered with nothing left to scan");

  a_scan_has_data: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan != '0))
    else $error("scanner running on an empty value");

  // a hit with a free output slot loads a result
  a_hit_emits: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && scan_hit && slot_free) |=> out_valid)
    else $error("scanner hit did not load a result");
`endif

endmodule

>>> tb/rotated_immediate_splitter_unit_tb.sv
module rotated_immediate_splitter_unit_tb;
  import ris_pkg::*;

  // one rotated piece as it leaves the output channel
  typedef struct packed {
    logic [CHUNK_W-1:0] chunk;
    logic [ROT_W-1:0]   rot;
    logic               last;
  } piece_t;

  // directed row: a constant, and a typed-in piece where it is obvious
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               typed;
    piece_t             want;
  } stim_row_t;

  localparam int NUM_ROWS     = 24;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_GAP      = 8;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CHUNK_W-1:0] chunk;
  logic [ROT_W-1:0]   rotate_right;
  logic               final_piece;

  piece_t      pending_pieces[$];   // pieces still owed by the block, oldest first
  int unsigned error_count = 0;
  int unsigned pieces_seen = 0;
  bit          send_calm = 1'b0;    // stretch with no gaps on the input side
  bit          take_calm = 1'b0;    // stretch with no stalls on the output side
  stim_row_t   directed_rows [NUM_ROWS];

  rotated_immediate_splitter_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .chunk        (chunk),
    .rotate_right (rotate_right),
    .final_piece  (final_piece)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #3000000;
    $display("rotated_immediate_splitter_unit test failed");
    $finish;
  end

  // split one constant into its rotated pieces and queue them
  function automatic void split_constant(input logic [VALUE_W-1:0] v);
    piece_t     p;
    int         pos;
    int         stop;
    int         n;
    bit         scanning;
    logic [5:0] rot_full;
    pos = 0;
    stop = VALUE_W;
    n = 0;
    if (v == '0) begin
      // zero constant: a single zero piece, flagged
      p.chunk = '0;
      p.rot = '0;
      p.last = 1'b1;
      pending_pieces.push_back(p);
      return;
    end
    if ((v & TOP_NIBBLE_MASK) != '0) begin
      // top nibble wraps around with the low nibble
      p.chunk = {v[NIBBLE_W-1:0], v[VALUE_W-1 -: NIBBLE_W]};
      p.rot = WRAP_ROT;
      p.last = 1'b0;
      pending_pieces.push_back(p);
      n = 1;
      pos = NIBBLE_W;
      stop = VALUE_W - NIBBLE_W;
    end
    scanning = 1'b1;
    while (scanning && n < 4) begin
      // skip zero pairs
      while (pos < stop && v[pos +: PAIR_W] == '0)
        pos += PAIR_W;
      if (pos >= stop) begin
        scanning = 1'b0;
      end else begin
        p.chunk = CHUNK_W'(v >> pos);
        rot_full = 6'd32 - 6'(pos);
        p.rot = rot_full[ROT_W-1:0];
        p.last = 1'b0;
        pending_pieces.push_back(p);
        n++;
        // a piece this close to the scan end closes the constant
        if (pos >= stop - CHUNK_W)
          scanning = 1'b0;
        else
          pos += CHUNK_W;
      end
    end
    pending_pieces[pending_pieces.size()-1].last = 1'b1;
  endfunction

  // gap before the next transfer; now and then switch to a gap-free stretch
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0)
      calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("mismatch on piece %0d, %s: got 0x%0h, expected 0x%0h",
             pieces_seen, what, got, want);
  endtask

  // offer one constant; the expectation is queued at the accepting edge
  task automatic send_value(input logic [VALUE_W-1:0] v, input logic typed,
                            input piece_t want);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (!in_ready);
    if (typed)
      pending_pieces.push_back(want);
    else
      split_constant(v);
  endtask

  // random constant, shaped to hit every scan path
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 7))
      0, 1: v = $urandom;
      // no wrapped piece, full 32-bit scan
      2: v = $urandom & ~TOP_NIBBLE_MASK;
      // a few isolated bits
      3: v = (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31)) |
             (($urandom_range(0, 1) != 0) ? (32'd1 << $urandom_range(0, 31)) : 32'd0);
      // wrapped piece plus bits near the top of the scan window (overlap)
      4: v = ($urandom & 32'hF000_000F) | (($urandom & 32'h3) << 26) |
             (($urandom & 32'h3) << 24);
      // one or two bytes on even boundaries
      5: v = (($urandom & 32'hFF) << (2 * $urandom_range(0, 12))) |
             (($urandom & 32'hFF) << (2 * $urandom_range(0, 12)));
      // top and low nibble only
      6: v = $urandom & 32'hF000_000F;
      default: v = ($urandom_range(0, 3) == 0) ? 32'd0 : ($urandom & $urandom);
    endcase
    return v;
  endfunction

  // input side: reset, directed table, then random constants
  initial begin
    directed_rows = '{
      // typed-in results: single obvious piece
      '{32'h0000_0000, 1'b1, '{8'h00, 5'd0, 1'b1}},   // zero constant
      '{32'hF000_0000, 1'b1, '{8'h0F, 5'd4, 1'b1}},   // top nibble only
      '{32'h1000_0000, 1'b1, '{8'h01, 5'd4, 1'b1}},
      '{32'h8000_0000, 1'b1, '{8'h08, 5'd4, 1'b1}},
      '{32'hF000_000F, 1'b1, '{8'hFF, 5'd4, 1'b1}},   // wrap holds everything
      '{32'h0000_00FF, 1'b1, '{8'hFF, 5'd0, 1'b1}},
      '{32'h0000_0001, 1'b1, '{8'h01, 5'd0, 1'b1}},
      '{32'h0000_0003, 1'b1, '{8'h03, 5'd0, 1'b1}},
      // the rest goes through the predictor
      '{32'hFFFF_FFFF, 1'b0, '0},   // four pieces with wrap
      '{32'h0FFF_FFFF, 1'b0, '0},   // four pieces without wrap
      '{32'h0C00_0000, 1'b0, '0},   // lone pair at bit 26, no wrap
      '{32'h4C00_0000, 1'b0, '0},   // overlap of piece at bit 26 with wrap
      '{32'h0800_0000, 1'b0, '0},
      '{32'h4000_0000, 1'b0, '0},
      '{32'h0000_0010, 1'b0, '0},
      '{32'h00FF_00FF, 1'b0, '0},
      '{32'h5555_5555, 1'b0, '0},
      '{32'hAAAA_AAAA, 1'b0, '0},
      '{32'h8000_0001, 1'b0, '0},
      '{32'h0000_0100, 1'b0, '0},
      '{32'h0101_0101, 1'b0, '0},
      '{32'h3000_0030, 1'b0, '0},
      '{32'hC000_0002, 1'b0, '0},   // top nibble with low bits only
      '{32'h0000_C000, 1'b0, '0}
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i])
      send_value(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
    repeat (RANDOM_ITEMS)
      send_value(random_value(), 1'b0, '0);
    in_valid <= 1'b0;
    // wait for every owed piece, then let the block settle
    while (pending_pieces.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("rotated_immediate_splitter_unit test passed");
    else
      $display("rotated_immediate_splitter_unit test failed");
    $finish;
  end

  // output side: random stalls before each transfer
  initial begin
    int gap;
    while (rst)
      @(posedge clk);
    forever begin
      gap = draw_gap(take_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // check each output transfer against the oldest owed piece
  always @(posedge clk) begin
    piece_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pieces.size() == 0) begin
        report_mismatch("piece with nothing owed", chunk, 0);
      end else begin
        want = pending_pieces.pop_front();
        if (chunk !== want.chunk)
          report_mismatch("chunk", chunk, want.chunk);
        if (rotate_right !== want.rot)
          report_mismatch("rotate_right", rotate_right, want.rot);
        if (final_piece !== want.last)
          report_mismatch("final_piece", final_piece, want.last);
      end
      pieces_seen++;
    end
  end

endmodule

>>> rotated_immediate_splitter_unit.f
rtl/ris_pkg.sv
rtl/rotated_immediate_splitter_unit.sv
tb/rotated_immediate_splitter_unit_tb.sv
